/* rtl/core/adff_pkg.sv */
`default_nettype none

package adff_pkg;

    // Status codes of the end-of-packet result
    localparam logic [3:0] ST_DELIVERED    = 4'd0;
    localparam logic [3:0] ST_TOO_SHORT    = 4'd1;
    localparam logic [3:0] ST_BAD_HEADER   = 4'd2;
    localparam logic [3:0] ST_POLL         = 4'd3;
    localparam logic [3:0] ST_OTHER_OP     = 4'd4;
    localparam logic [3:0] ST_SHORT_OUTPUT = 4'd5;
    localparam logic [3:0] ST_VERSION      = 4'd6;
    localparam logic [3:0] ST_NOT_OURS     = 4'd7;
    localparam logic [3:0] ST_LENGTH       = 4'd8;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_NET      = 2'd0;
    localparam logic [1:0] CFG_SUBNET   = 2'd1;
    localparam logic [1:0] CFG_UNIVERSE = 2'd2;

    // Opcodes and protocol constants
    localparam logic [15:0] OP_POLL    = 16'h2000;
    localparam logic [15:0] OP_OUTPUT  = 16'h5000;
    localparam logic [15:0] PROTO_VER  = 16'd14;
    localparam logic [16:0] MIN_LEN    = 17'd10;
    localparam logic [16:0] HDR_LEN    = 17'd18;

    // Packet offsets of the header fields
    localparam logic [15:0] POS_OP_LO  = 16'd8;
    localparam logic [15:0] POS_OP_HI  = 16'd9;
    localparam logic [15:0] POS_VER_HI = 16'd10;
    localparam logic [15:0] POS_VER_LO = 16'd11;
    localparam logic [15:0] POS_SUBUNI = 16'd14;
    localparam logic [15:0] POS_NET    = 16'd15;
    localparam logic [15:0] POS_LEN_HI = 16'd16;
    localparam logic [15:0] POS_LEN_LO = 16'd17;
    localparam logic [15:0] POS_DATA   = 16'd18;

    typedef struct packed {
        logic [7:0] net;
        logic [3:0] subnet;
        logic [3:0] universe;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [10:0] byte_index;
        logic [9:0] led_count;
        logic       last;
        logic [3:0] status;
    } result_t;

    // Up to two results per input beat, data before status
    typedef struct packed {
        logic    fwd_valid;
        result_t fwd;
        logic    stat_valid;
        result_t stat;
    } push_t;

    // "Art-Net\0" identifier
    function automatic logic [7:0] ident_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Packet verdict from the fields captured so far
    function automatic logic [3:0] status_of(
        input logic [16:0] len,
        input logic        hdr_good,
        input logic [15:0] opcode,
        input logic [15:0] version,
        input logic [7:0]  subuni,
        input logic [7:0]  net,
        input logic [15:0] led_count,
        input cfg_t        cfg
    );
        logic [17:0] need;
        logic [17:0] avail;
        logic [3:0]  st;
        need  = {2'b00, led_count} + {1'b0, led_count, 1'b0};
        avail = {1'b0, len} - {1'b0, HDR_LEN};
        if (len < MIN_LEN) begin
            st = ST_TOO_SHORT;
        end else if (!hdr_good) begin
            st = ST_BAD_HEADER;
        end else if (opcode == OP_POLL) begin
            st = ST_POLL;
        end else if (opcode != OP_OUTPUT) begin
            st = ST_OTHER_OP;
        end else if (len < HDR_LEN) begin
            st = ST_SHORT_OUTPUT;
        end else if (version != PROTO_VER) begin
            st = ST_VERSION;
        end else if (net != cfg.net || subuni[7:4] != cfg.subnet
                     || subuni[3:0] != cfg.universe) begin
            st = ST_NOT_OURS;
        end else if (avail < need) begin
            // floor((len-18)/3) < L is the same as len-18 < 3L
            st = ST_LENGTH;
        end else begin
            st = ST_DELIVERED;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adff_parser.sv */
`default_nettype none

module adff_parser #(
    parameter int MAX_LEDS = 512
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire adff_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_first,
    input  wire logic [15:0]          in_plen,
    input  wire logic                 room,
    output adff_pkg::push_t           push
);

    localparam logic [16:0] BUF_LEN = 17'(18 + 3 * MAX_LEDS);

    localparam logic [15:0] POS_OP_LO  = adff_pkg::POS_OP_LO;
    localparam logic [15:0] POS_OP_HI  = adff_pkg::POS_OP_HI;
    localparam logic [15:0] POS_VER_HI = adff_pkg::POS_VER_HI;
    localparam logic [15:0] POS_VER_LO = adff_pkg::POS_VER_LO;
    localparam logic [15:0] POS_SUBUNI = adff_pkg::POS_SUBUNI;
    localparam logic [15:0] POS_NET    = adff_pkg::POS_NET;
    localparam logic [15:0] POS_LEN_HI = adff_pkg::POS_LEN_HI;
    localparam logic [15:0] POS_LEN_LO = adff_pkg::POS_LEN_LO;
    localparam logic [15:0] POS_DATA   = adff_pkg::POS_DATA;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        first_reg;
    logic [15:0] plen_reg;

    // Packet state
    logic [15:0] pos_reg,     pos_next;
    logic        hdr_reg,     hdr_next;
    logic [15:0] op_reg,      op_next;
    logic [15:0] ver_reg,     ver_next;
    logic [7:0]  subuni_reg,  subuni_next;
    logic [7:0]  net_reg,     net_next;
    logic [15:0] ledcnt_reg,  ledcnt_next;
    logic        acc_reg,     acc_next;

    logic        advance;
    logic [15:0] p;
    logic [15:0] plen_m1;
    logic [16:0] plen_eff;
    logic [16:0] len;
    logic        in_range;
    logic        acc_base;
    logic [3:0]  status;
    logic [15:0] idx;
    logic [17:0] data_len;
    logic        fwd;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;

    // Beat capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            byte_reg  <= in_byte;
            first_reg <= in_first;
            plen_reg  <= in_plen;
        end
    end

    // Effective lengths
    always_comb begin
        plen_eff = (plen_reg == 16'd0) ? 17'd1 : {1'b0, plen_reg};
        plen_m1  = (plen_reg == 16'd0) ? 16'd0 : plen_reg - 16'd1;
        len      = (plen_eff < BUF_LEN) ? plen_eff : BUF_LEN;
    end

    // Header capture, starting from cleared state on a first beat
    always_comb begin
        p           = first_reg ? 16'd0  : pos_reg;
        hdr_next    = first_reg ? 1'b1   : hdr_reg;
        op_next     = first_reg ? 16'd0  : op_reg;
        ver_next    = first_reg ? 16'd0  : ver_reg;
        subuni_next = first_reg ? 8'd0   : subuni_reg;
        net_next    = first_reg ? 8'd0   : net_reg;
        ledcnt_next = first_reg ? 16'd0  : ledcnt_reg;
        acc_base    = first_reg ? 1'b0   : acc_reg;
        in_range    = {1'b0, p} < len;
        if (in_range) begin
            if (p < POS_OP_LO) begin
                if (byte_reg != adff_pkg::ident_byte(p[2:0])) begin
                    hdr_next = 1'b0;
                end
            end else if (p == POS_OP_LO) begin
                op_next[7:0] = byte_reg;
            end else if (p == POS_OP_HI) begin
                op_next[15:8] = byte_reg;
            end else if (p == POS_VER_HI) begin
                ver_next[15:8] = byte_reg;
            end else if (p == POS_VER_LO) begin
                ver_next[7:0] = byte_reg;
            end else if (p == POS_SUBUNI) begin
                subuni_next = byte_reg;
            end else if (p == POS_NET) begin
                net_next = byte_reg;
            end else if (p == POS_LEN_HI) begin
                ledcnt_next[15:8] = byte_reg;
            end else if (p == POS_LEN_LO) begin
                ledcnt_next[7:0] = byte_reg;
            end
        end
        pos_next = (p != 16'hFFFF) ? p + 16'd1 : p;
    end

    // Verdict on the updated fields; latched on the last header byte
    always_comb begin
        status   = adff_pkg::status_of(len, hdr_next, op_next, ver_next,
                                       subuni_next, net_next, ledcnt_next, cfg);
        acc_next = acc_base;
        if (in_range && p == POS_LEN_LO) begin
            acc_next = (status == adff_pkg::ST_DELIVERED);
        end
    end

    // LED data forwarding
    always_comb begin
        idx      = p - POS_DATA;
        data_len = {2'b00, ledcnt_next} + {1'b0, ledcnt_next, 1'b0};
        fwd      = in_range && (p >= POS_DATA) && acc_base
                   && ({2'b00, idx} < data_len);

        push.fwd_valid         = advance && fwd;
        push.fwd.kind          = adff_pkg::KIND_DATA;
        push.fwd.payload_byte  = byte_reg;
        push.fwd.byte_index    = idx[10:0];
        push.fwd.led_count     = ledcnt_next[9:0];
        push.fwd.last          = ({2'b00, idx} + 18'd1) == data_len;
        push.fwd.status        = adff_pkg::ST_DELIVERED;

        push.stat_valid        = advance && (p == plen_m1);
        push.stat.kind         = adff_pkg::KIND_STATUS;
        push.stat.payload_byte = 8'd0;
        push.stat.byte_index   = 11'd0;
        push.stat.led_count    = (status == adff_pkg::ST_DELIVERED)
                                 ? ledcnt_next[9:0] : 10'd0;
        push.stat.last         = 1'b0;
        push.stat.status       = status;
    end

    // Packet state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 16'd0;
            hdr_reg    <= 1'b1;
            op_reg     <= 16'd0;
            ver_reg    <= 16'd0;
            subuni_reg <= 8'd0;
            net_reg    <= 8'd0;
            ledcnt_reg <= 16'd0;
            acc_reg    <= 1'b0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            hdr_reg    <= hdr_next;
            op_reg     <= op_next;
            ver_reg    <= ver_next;
            subuni_reg <= subuni_next;
            net_reg    <= net_next;
            ledcnt_reg <= ledcnt_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adff_out_queue.sv */
`default_nettype none

module adff_out_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire adff_pkg::push_t     push,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output adff_pkg::result_t        out_data
);

    adff_pkg::result_t entry_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;
    adff_pkg::result_t slot0;

    // Two free entries guarantee space for both results of a beat
    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_data  = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        n_push     = {1'b0, push.fwd_valid} + {1'b0, push.stat_valid};
        slot0      = push.fwd_valid ? push.fwd : push.stat;
        tail_next  = tail_reg + n_push;
        head_next  = head_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry writes, data beat ahead of status
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entry_reg[tail_reg] <= slot0;
        end
        if (n_push == 2'd2) begin
            entry_reg[tail_reg + 2'd1] <= push.stat;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/artnet_dmx_frame_filter_top.sv */
`default_nettype none

// Art-Net OpOutput frame filter. Takes a UDP payload one byte per beat and
// passes on the LED bytes of frames that carry the Art-Net identifier, opcode
// OpOutput, version 14, our net/subnet/universe and a Length whose 3*Length
// bytes fit in the packet; bytes at or past 18+3*MAX_LEDS are ignored. The last
// byte of each packet also yields a status beat (m_tuser high) after any data
// beat. One byte is accepted every cycle unless input is stalled; results are
// registered in the input register and then a four-entry result queue, which
// stalls input only when the queue holds three or more results. Configuration
// is written through cfg_* while the stream is idle.
module artnet_dmx_frame_filter_top #(
    parameter int MAX_LEDS = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] packet_length
    input  wire logic        s_tuser,   // first_of_packet
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] payload_byte, [18:8] byte_index,
                                        // [28:19] led_count, [32:29] status_code
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // last_of_run
);

    adff_pkg::cfg_t    cfg_reg;
    adff_pkg::push_t   push;
    adff_pkg::result_t res;
    logic              room;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                adff_pkg::CFG_NET:      cfg_reg.net      <= cfg_data;
                adff_pkg::CFG_SUBNET:   cfg_reg.subnet   <= cfg_data[3:0];
                adff_pkg::CFG_UNIVERSE: cfg_reg.universe <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    adff_parser #(
        .MAX_LEDS (MAX_LEDS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata[7:0]),
        .in_first (s_tuser),
        .in_plen  (s_tdata[23:8]),
        .room     (room),
        .push     (push)
    );

    adff_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Result beat packing
    assign m_tdata = {7'd0, res.status, res.led_count, res.byte_index, res.payload_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

/* tb/artnet_dmx_frame_filter_checker.sv */
`default_nettype none

// Watches the config, byte and result channels of the Art-Net frame filter,
// predicts every result beat from the accepted byte beats and compares them
// in order.
module artnet_dmx_frame_filter_checker
    import adff_pkg::*;
#(
    parameter int LED_LIMIT = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] packet_length
    input  wire logic        s_tuser,   // first_of_packet
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // [7:0] payload_byte, [18:8] byte_index,
                                        // [28:19] led_count, [32:29] status_code
    input  wire logic        m_tuser,   // result_kind
    input  wire logic        m_tlast,   // last_of_run
    output int               mismatch_count,
    output int               pending_results
);

    // receive buffer size: bytes at or past this offset are dropped
    localparam int BUF_BYTES = 18 + 3 * LED_LIMIT;
    // "Art-Net\0", byte 0 in the low bits
    localparam logic [63:0] ART_ID = 64'h00_74_65_4E_2D_74_72_41;

    // node address as last written
    logic [7:0]  net_reg;
    logic [3:0]  sub_reg;
    logic [3:0]  uni_reg;

    // per-packet parse state
    logic [15:0] pos;
    logic        hdr_ok;
    logic [15:0] opcode;
    logic [15:0] version;
    logic [7:0]  subuni;
    logic [7:0]  net_seen;
    logic [15:0] led_field;
    logic        accepted;

    result_t     expected_q [$];
    int          errors = 0;

    assign mismatch_count = errors;

    task automatic clear_packet();
        pos       = '0;
        hdr_ok    = 1'b1;
        opcode    = '0;
        version   = '0;
        subuni    = '0;
        net_seen  = '0;
        led_field = '0;
        accepted  = 1'b0;
    endtask

    // packet verdict from the header fields seen so far
    function automatic logic [3:0] verdict(input int len);
        logic [3:0] st;
        if (len < int'(MIN_LEN)) begin
            st = ST_TOO_SHORT;
        end else if (!hdr_ok) begin
            st = ST_BAD_HEADER;
        end else if (opcode == OP_POLL) begin
            st = ST_POLL;
        end else if (opcode != OP_OUTPUT) begin
            st = ST_OTHER_OP;
        end else if (len < int'(HDR_LEN)) begin
            st = ST_SHORT_OUTPUT;
        end else if (version != PROTO_VER) begin
            st = ST_VERSION;
        end else if (net_seen != net_reg || subuni[7:4] != sub_reg
                     || subuni[3:0] != uni_reg) begin
            st = ST_NOT_OURS;
        end else if ((len - int'(HDR_LEN)) / 3 < int'(led_field)) begin
            st = ST_LENGTH;
        end else begin
            st = ST_DELIVERED;
        end
        return st;
    endfunction

    // one accepted input byte: update the parse state, queue its results
    task automatic apply_byte(input logic [7:0] b, input logic first,
                              input logic [15:0] plen);
        int      span;
        int      len;
        int      p;
        int      idx;
        result_t r;
        if (first) clear_packet();
        span = (plen == 16'd0) ? 1 : int'(plen);
        len  = (span < BUF_BYTES) ? span : BUF_BYTES;
        p    = int'(pos);
        if (p < len) begin
            if (p < 8) begin
                if (b != ART_ID[p*8 +: 8]) hdr_ok = 1'b0;
            end else begin
                case (p)
                    int'(POS_OP_LO):  opcode[7:0]     = b;
                    int'(POS_OP_HI):  opcode[15:8]    = b;
                    int'(POS_VER_HI): version[15:8]   = b;
                    int'(POS_VER_LO): version[7:0]    = b;
                    int'(POS_SUBUNI): subuni          = b;
                    int'(POS_NET):    net_seen        = b;
                    int'(POS_LEN_HI): led_field[15:8] = b;
                    int'(POS_LEN_LO): begin
                        led_field[7:0] = b;
                        accepted = (verdict(len) == ST_DELIVERED);
                    end
                    default: begin
                        idx = p - int'(POS_DATA);
                        if (idx >= 0 && accepted && idx < 3 * int'(led_field)) begin
                            r              = '0;
                            r.kind         = KIND_DATA;
                            r.payload_byte = b;
                            r.byte_index   = 11'(idx);
                            r.led_count    = led_field[9:0];
                            r.last         = (idx + 1 == 3 * int'(led_field));
                            expected_q.push_back(r);
                        end
                    end
                endcase
            end
        end
        // final byte of the packet: status beat after any data beat
        if (p == span - 1) begin
            r        = '0;
            r.kind   = KIND_STATUS;
            r.status = verdict(len);
            if (r.status == ST_DELIVERED) r.led_count = led_field[9:0];
            expected_q.push_back(r);
        end
        if (pos != 16'hFFFF) pos = pos + 16'd1;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic check_result();
        result_t seen;
        result_t want;
        seen              = '0;
        seen.kind         = m_tuser;
        seen.payload_byte = m_tdata[7:0];
        seen.byte_index   = m_tdata[18:8];
        seen.led_count    = m_tdata[28:19];
        seen.status       = m_tdata[32:29];
        seen.last         = m_tlast;
        if (expected_q.size() == 0) begin
            flag_mismatch("result beat with nothing expected, status_code",
                          seen.status, -1);
        end else begin
            want = expected_q.pop_front();
            if (seen.kind != want.kind)
                flag_mismatch("result_kind", seen.kind, want.kind);
            if (seen.payload_byte != want.payload_byte)
                flag_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
            if (seen.byte_index != want.byte_index)
                flag_mismatch("byte_index", seen.byte_index, want.byte_index);
            if (seen.led_count != want.led_count)
                flag_mismatch("led_count", seen.led_count, want.led_count);
            if (seen.last != want.last)
                flag_mismatch("last_of_run", seen.last, want.last);
            if (seen.status != want.status)
                flag_mismatch("status_code", seen.status, want.status);
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            net_reg = '0;
            sub_reg = '0;
            uni_reg = '0;
            clear_packet();
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NET:      net_reg = cfg_data;
                    CFG_SUBNET:   sub_reg = cfg_data[3:0];
                    CFG_UNIVERSE: uni_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) apply_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]);
            if (m_tvalid && m_tready) check_result();
        end
        pending_results <= expected_q.size();
    end

endmodule

`default_nettype wire

/* tb/tb_artnet_dmx_frame_filter_top.sv */
`default_nettype none

module tb_artnet_dmx_frame_filter_top;
    import adff_pkg::*;

    localparam int LED_LIMIT    = 512;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 350;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_NET;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // [7:0] data_byte, [23:8] packet_length
    logic        s_tuser   = 1'b0;  // first_of_packet
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [7:0] payload_byte, [18:8] byte_index,
                                    // [28:19] led_count, [32:29] status_code
    logic        m_tuser;           // result_kind
    logic        m_tlast;           // last_of_run

    int          fails;
    int          pending;
    int          cycle_count = 0;
    int          items_sent  = 0;
    logic        quiet = 1'b0;      // no idling at all
    logic        calm  = 1'b0;      // stretches without idling

    // node address as programmed, used to build matching frames
    logic [7:0]  net_cfg = '0;
    logic [3:0]  sub_cfg = '0;
    logic [3:0]  uni_cfg = '0;

    logic [7:0]  frame_q [$];

    artnet_dmx_frame_filter_top #(
        .MAX_LEDS (LED_LIMIT)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    artnet_dmx_frame_filter_checker #(
        .LED_LIMIT (LED_LIMIT)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (fails),
        .pending_results (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // switch between busy and calm stretches
    always @(posedge aclk) begin
        if (cycle_count % 300 == 0) calm <= ($urandom_range(0, 2) == 0);
    end

    // result side back-pressure in random bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one byte beat, with an optional gap in front of it
    task automatic push_byte(input logic [7:0] b, input logic first,
                             input logic [15:0] plen);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, b};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // header of an ArtDmx-shaped frame; the LED data is filled in while sending
    task automatic build_frame(input logic [15:0] op, input logic [15:0] ver,
                               input logic [7:0] su, input logic [7:0] nt,
                               input logic [15:0] leds);
        frame_q.delete();
        for (int i = 0; i < 8; i++) frame_q.push_back(ident_byte(3'(i)));
        frame_q.push_back(op[7:0]);
        frame_q.push_back(op[15:8]);
        frame_q.push_back(ver[15:8]);
        frame_q.push_back(ver[7:0]);
        frame_q.push_back(8'($urandom));    // sequence
        frame_q.push_back(8'($urandom));    // physical port
        frame_q.push_back(su);
        frame_q.push_back(nt);
        frame_q.push_back(leds[15:8]);
        frame_q.push_back(leds[7:0]);
    endtask

    // send n bytes of the current frame, random bytes past its end
    task automatic send_frame(input logic [15:0] plen, input int n, input logic jitter);
        logic [7:0]  b;
        logic [15:0] l;
        for (int i = 0; i < n; i++) begin
            b = (i < frame_q.size()) ? frame_q[i] : 8'($urandom);
            l = plen;
            if (jitter)
                l = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 24));
            push_byte(b, i == 0, l);
        end
    endtask

    task automatic random_packet();
        int          pick;
        int          leds;
        int          plen;
        int          n;
        logic [15:0] op;
        logic [15:0] ver;
        logic [15:0] led_field;
        logic [7:0]  su;
        logic [7:0]  nt;
        logic        jitter;
        op     = OP_OUTPUT;
        ver    = PROTO_VER;
        su     = {sub_cfg, uni_cfg};
        nt     = net_cfg;
        jitter = 1'b0;
        n      = -1;
        leds   = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 200)
                                              : $urandom_range(0, 8);
        led_field = 16'(leds);
        plen = 18 + 3 * leds + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        pick = $urandom_range(0, 31);
        case (pick)
            1:  op = OP_POLL;
            2:  op = 16'($urandom);
            3:  ver = 16'($urandom);
            4:  ver = {PROTO_VER[7:0], PROTO_VER[15:8]};    // byte order swapped
            5:  nt = nt ^ 8'($urandom_range(1, 255));
            6:  su[7:4] = su[7:4] ^ 4'($urandom_range(1, 15));
            7:  su[3:0] = su[3:0] ^ 4'($urandom_range(1, 15));
            // Length a little above what the packet holds
            8: begin
                plen      = 18 + 3 * leds + $urandom_range(0, 2);
                led_field = 16'(leds + $urandom_range(1, 3));
            end
            9:  led_field = 16'($urandom);
            10: plen = $urandom_range(1, 17);
            // cut short: next packet starts before the last byte
            11: n = $urandom_range(1, plen - 1);
            // stray bytes after the end of the packet
            12: n = plen + $urandom_range(1, 4);
            13: begin
                plen = $urandom_range(1, 40);
                n    = $urandom_range(1, 40);
            end
            14: begin
                jitter = 1'b1;
                n      = $urandom_range(1, 24);
            end
            default: ;
        endcase
        build_frame(op, ver, su, nt, led_field);
        if (pick == 0) frame_q[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
        if (pick == 13 || pick == 14) frame_q.delete();
        if (n < 0) n = plen;
        send_frame(16'(plen), n, jitter);
    endtask

    // stop input, wait for every expected result and let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // subnet and universe take the low nibble only
    task automatic set_address(input logic [7:0] nt, input logic [7:0] sub,
                               input logic [7:0] uni);
        write_reg(CFG_NET, nt);
        write_reg(CFG_SUBNET, sub);
        write_reg(CFG_UNIVERSE, uni);
        cfg_valid <= 1'b0;
        net_cfg = nt;
        sub_cfg = sub[3:0];
        uni_cfg = uni[3:0];
    endtask

    task automatic random_phase();
        int stop_at;
        stop_at = items_sent + PHASE_BYTES;
        while (items_sent < stop_at) random_packet();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // first byte after reset carries no start flag; zero length counts as one
        push_byte(8'hFF, 1'b0, 16'h0000);
        push_byte(8'h00, 1'b1, 16'h0001);
        // one-LED delivered frame at the reset address, then one stray byte
        build_frame(OP_OUTPUT, PROTO_VER, 8'h00, 8'h00, 16'd1);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hA5);
        send_frame(16'd21, 22, 1'b0);

        drain();
        set_address(8'hFF, 8'hFF, 8'hFF);
        random_phase();

        // full-size Length in the longest packet: accepted against the clamped
        // length, cut short by the next packet
        drain();
        set_address(8'($urandom), 8'($urandom), 8'($urandom));
        build_frame(OP_OUTPUT, PROTO_VER, {sub_cfg, uni_cfg}, net_cfg, 16'(LED_LIMIT));
        send_frame(16'hFFFF, 60, 1'b0);
        random_phase();

        drain();
        set_address(8'h00, 8'h00, 8'h00);
        random_phase();

        // closing phase runs without any idling
        drain();
        set_address(8'($urandom), 8'($urandom), 8'($urandom));
        quiet = 1'b1;
        random_phase();

        drain();
        if (fails == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/adff_pkg.sv
rtl/core/adff_parser.sv
rtl/core/adff_out_queue.sv
rtl/core/artnet_dmx_frame_filter_top.sv
tb/artnet_dmx_frame_filter_checker.sv
tb/tb_artnet_dmx_frame_filter_top.sv
